// File: design/lbhg_pkg.sv
`default_nettype none
package lbhg_pkg;

  localparam int unsigned NCORES = 4;
  localparam int unsigned IDX_W  = (NCORES > 1) ? $clog2(NCORES) : 1;
  localparam int unsigned CNT_W  = $clog2(NCORES + 2);
  localparam int unsigned LOAD_W = 7;
  localparam int unsigned SUM_W  = $clog2(NCORES * 100 + 1);
  localparam int unsigned CTR_W  = 9;
  localparam int unsigned MASK_W = 4;

  localparam int unsigned DIV_Q_W   = 7;
  localparam int unsigned DIV_DEN_W = 32;
  localparam int unsigned DIV_NUM_W = DIV_DEN_W + DIV_Q_W;

  localparam logic [LOAD_W-1:0] FULL_LOAD      = 7'd100;
  localparam logic [LOAD_W-1:0] SINGLE_UP_LOAD = 7'd30;
  localparam logic [CTR_W-1:0]  COUNT_MAX      = 9'd511;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALL_UP_LOAD  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_UP_LOAD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UP_HOLD      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DOWN_HOLD    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FEWEST_CORES = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MOST_CORES   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_FREQ     = 3'd7;

  localparam logic [6:0]  RST_ALL_UP_LOAD  = 7'd98;
  localparam logic [6:0]  RST_ONE_UP_LOAD  = 7'd60;
  localparam logic [7:0]  RST_UP_HOLD      = 8'd2;
  localparam logic [7:0]  RST_DOWN_HOLD    = 8'd10;
  localparam logic [2:0]  RST_FEWEST_CORES = 3'd1;
  localparam logic [2:0]  RST_MOST_CORES   = 3'd4;
  localparam logic [31:0] RST_TOP_FREQ     = 32'd1000000;

  localparam logic [1:0] ACT_NONE   = 2'd0;
  localparam logic [1:0] ACT_PLUG   = 2'd1;
  localparam logic [1:0] ACT_UNPLUG = 2'd2;

  localparam logic [1:0] DSEL_BUSY  = 2'd0;
  localparam logic [1:0] DSEL_SCALE = 2'd1;
  localparam logic [1:0] DSEL_AVG   = 2'd2;

  typedef struct packed {
    logic [1:0]  core_index;
    logic [63:0] total_wall_time;
    logic [63:0] total_idle_time;
    logic [31:0] present_frequency;
    logic        idle_now;
    logic        round_end;
  } in_t;

  typedef struct packed {
    logic [3:0] online_cores_mask;
    logic [2:0] online_before;
    logic [6:0] average_load;
    logic [1:0] action_taken;
    logic [8:0] up_counter;
    logic [8:0] down_counter;
  } out_t;

  typedef struct packed {
    logic       capture;
    logic       calc;
    logic       div_start;
    logic [1:0] div_sel;
    logic       busy_take;
    logic       mul;
    logic       load_wr;
    logic       sum;
    logic       avg_take;
    logic       decide;
  } cmd_t;

  typedef struct packed {
    logic enabled;
    logic sample_ok;
    logic degenerate;
    logic round_end;
    logic div_done;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

// File: design/lbhg_div.sv
`default_nettype none
module lbhg_div (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic [lbhg_pkg::DIV_NUM_W-1:0]  num_i,
  input  wire logic [lbhg_pkg::DIV_DEN_W-1:0]  den_i,
  output logic                                 done_o,
  output logic [lbhg_pkg::DIV_Q_W-1:0]         quot_o,
  output logic                                 ovf_o
);

  localparam int unsigned QW   = lbhg_pkg::DIV_Q_W;
  localparam int unsigned DW   = lbhg_pkg::DIV_DEN_W;
  localparam int unsigned CW   = $clog2(QW + 1);

  logic [DW-1:0] rem_q, den_q;
  logic [QW-1:0] low_q, quot_q;
  logic [CW-1:0] cnt_q;
  logic          run_q, done_q, ovf_q;

  logic [DW:0]   shifted, diff;
  logic          ge;

  assign shifted = {rem_q, low_q[QW-1]};
  assign ge      = shifted >= {1'b0, den_q};
  assign diff    = shifted - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= run_q && (cnt_q == CW'(1));
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CW'(QW);
      end else if (run_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= num_i[DW+QW-1:QW];
      low_q  <= num_i[QW-1:0];
      den_q  <= den_i;
      quot_q <= '0;
      ovf_q  <= num_i[DW+QW-1:QW] >= den_i;
    end else if (run_q) begin
      rem_q  <= ge ? diff[DW-1:0] : shifted[DW-1:0];
      low_q  <= {low_q[QW-2:0], 1'b0};
      quot_q <= {quot_q[QW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign ovf_o  = ovf_q;

endmodule
`default_nettype wire

// File: design/lbhg_ctrl.sv
`default_nettype none
module lbhg_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire lbhg_pkg::stat_t stat_i,
  output lbhg_pkg::cmd_t       cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CALC   = 4'd1;
  localparam logic [3:0] S_CHECK  = 4'd2;
  localparam logic [3:0] S_BWAIT  = 4'd3;
  localparam logic [3:0] S_MUL    = 4'd4;
  localparam logic [3:0] S_SSTART = 4'd5;
  localparam logic [3:0] S_SWAIT  = 4'd6;
  localparam logic [3:0] S_SUM    = 4'd7;
  localparam logic [3:0] S_ASTART = 4'd8;
  localparam logic [3:0] S_AWAIT  = 4'd9;
  localparam logic [3:0] S_DECIDE = 4'd10;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_CALC;
        end
      end
      S_CALC: begin
        if (!stat_i.enabled) begin
          state_d = S_IDLE;
        end else if (stat_i.sample_ok) begin
          cmd_o.calc = 1'b1;
          state_d    = S_CHECK;
        end else begin
          state_d = stat_i.round_end ? S_SUM : S_IDLE;
        end
      end
      S_CHECK: begin
        if (stat_i.degenerate) begin
          state_d = stat_i.round_end ? S_SUM : S_IDLE;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = lbhg_pkg::DSEL_BUSY;
          state_d         = S_BWAIT;
        end
      end
      S_BWAIT: begin
        cmd_o.div_sel = lbhg_pkg::DSEL_BUSY;
        if (stat_i.div_done) begin
          cmd_o.busy_take = 1'b1;
          state_d         = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_SSTART;
      end
      S_SSTART: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = lbhg_pkg::DSEL_SCALE;
        state_d         = S_SWAIT;
      end
      S_SWAIT: begin
        cmd_o.div_sel = lbhg_pkg::DSEL_SCALE;
        if (stat_i.div_done) begin
          cmd_o.load_wr = 1'b1;
          state_d       = stat_i.round_end ? S_SUM : S_IDLE;
        end
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = S_ASTART;
      end
      S_ASTART: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = lbhg_pkg::DSEL_AVG;
        state_d         = S_AWAIT;
      end
      S_AWAIT: begin
        cmd_o.div_sel = lbhg_pkg::DSEL_AVG;
        if (stat_i.div_done) begin
          cmd_o.avg_take = 1'b1;
          state_d        = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat_i.out_free) begin
          cmd_o.decide = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: design/lbhg_dpath.sv
`default_nettype none
module lbhg_dpath (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire lbhg_pkg::in_t                    in_data_i,
  input  wire logic                             cfg_we_i,
  input  wire logic [lbhg_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [lbhg_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output lbhg_pkg::out_t                        out_data_o,
  input  wire lbhg_pkg::cmd_t                   cmd_i,
  output lbhg_pkg::stat_t                       stat_o
);

  localparam int unsigned N   = lbhg_pkg::NCORES;
  localparam int unsigned IW  = lbhg_pkg::IDX_W;
  localparam int unsigned CW  = lbhg_pkg::CNT_W;
  localparam int unsigned LW  = lbhg_pkg::LOAD_W;
  localparam int unsigned SW  = lbhg_pkg::SUM_W;
  localparam int unsigned TW  = lbhg_pkg::CTR_W;
  localparam int unsigned NW  = lbhg_pkg::DIV_NUM_W;
  localparam int unsigned DW  = lbhg_pkg::DIV_DEN_W;
  localparam int unsigned QW  = lbhg_pkg::DIV_Q_W;
  localparam int unsigned MW  = lbhg_pkg::MASK_W;

  // configuration
  logic        enable_q;
  logic [6:0]  all_up_q, one_up_q;
  logic [7:0]  up_hold_q, down_hold_q;
  logic [2:0]  fewest_q, most_q;
  logic [31:0] top_freq_q;

  // per-core state
  logic [63:0]   last_wall_q [N];
  logic [63:0]   last_idle_q [N];
  logic [LW-1:0] load_q      [N];
  logic [N-1:0]  idle_q;
  logic [N-1:0]  online_q;
  logic [TW-1:0] up_q, down_q;

  // working registers
  lbhg_pkg::in_t  smp_q;
  logic [31:0]    wd_q, id_q;
  logic [LW-1:0]  busy_q, avg_q;
  logic [NW-1:0]  prod_q;
  logic [SW-1:0]  sum_q;
  logic [CW-1:0]  on_cnt_q;
  lbhg_pkg::out_t out_q;
  logic           out_valid_q;

  logic [IW-1:0]  idx;
  logic           idx_ok;
  logic [63:0]    wall_diff, idle_diff;
  logic [NW-1:0]  div_num;
  logic [DW-1:0]  div_den;
  logic           div_done, div_ovf;
  logic [QW-1:0]  div_quot;
  logic [LW-1:0]  scaled_load;
  logic [SW-1:0]  sum_d;
  logic [CW-1:0]  cnt_d;

  assign idx       = IW'(smp_q.core_index);
  assign idx_ok    = 32'(smp_q.core_index) < N;
  assign wall_diff = smp_q.total_wall_time - last_wall_q[idx];
  assign idle_diff = smp_q.total_idle_time - last_idle_q[idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= 1'b1;
      all_up_q    <= lbhg_pkg::RST_ALL_UP_LOAD;
      one_up_q    <= lbhg_pkg::RST_ONE_UP_LOAD;
      up_hold_q   <= lbhg_pkg::RST_UP_HOLD;
      down_hold_q <= lbhg_pkg::RST_DOWN_HOLD;
      fewest_q    <= lbhg_pkg::RST_FEWEST_CORES;
      most_q      <= lbhg_pkg::RST_MOST_CORES;
      top_freq_q  <= lbhg_pkg::RST_TOP_FREQ;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lbhg_pkg::CFG_ENABLE:       enable_q    <= cfg_data_i[0];
        lbhg_pkg::CFG_ALL_UP_LOAD:  all_up_q    <= cfg_data_i[6:0];
        lbhg_pkg::CFG_ONE_UP_LOAD:  one_up_q    <= cfg_data_i[6:0];
        lbhg_pkg::CFG_UP_HOLD:      up_hold_q   <= cfg_data_i[7:0];
        lbhg_pkg::CFG_DOWN_HOLD:    down_hold_q <= cfg_data_i[7:0];
        lbhg_pkg::CFG_FEWEST_CORES: fewest_q    <= cfg_data_i[2:0];
        lbhg_pkg::CFG_MOST_CORES:   most_q      <= cfg_data_i[2:0];
        lbhg_pkg::CFG_TOP_FREQ:     top_freq_q  <= cfg_data_i[31:0];
        default: begin
        end
      endcase
    end
  end

  // divider operand select
  always_comb begin
    div_num = '0;
    div_den = '0;
    case (cmd_i.div_sel)
      lbhg_pkg::DSEL_BUSY: begin
        div_num = NW'(wd_q - id_q) * NW'(lbhg_pkg::FULL_LOAD);
        div_den = wd_q;
      end
      lbhg_pkg::DSEL_SCALE: begin
        div_num = prod_q;
        div_den = (top_freq_q == '0) ? DW'(1) : top_freq_q;
      end
      lbhg_pkg::DSEL_AVG: begin
        div_num = NW'(sum_q);
        div_den = DW'(on_cnt_q);
      end
      default: begin
      end
    endcase
  end

  lbhg_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot),
    .ovf_o   (div_ovf)
  );

  assign scaled_load = (div_ovf || (div_quot > lbhg_pkg::FULL_LOAD)) ?
                       lbhg_pkg::FULL_LOAD : div_quot;

  always_comb begin
    sum_d = '0;
    cnt_d = '0;
    for (int c = 0; c < N; c++) begin
      if (online_q[c]) begin
        sum_d = sum_d + SW'(load_q[c]);
        cnt_d = cnt_d + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      smp_q <= in_data_i;
    end
    if (cmd_i.calc) begin
      wd_q <= wall_diff[31:0];
      id_q <= idle_diff[31:0];
    end
    if (cmd_i.busy_take) begin
      busy_q <= div_quot;
    end
    if (cmd_i.mul) begin
      prod_q <= NW'(busy_q) * NW'(smp_q.present_frequency);
    end
    if (cmd_i.sum) begin
      sum_q    <= sum_d;
      on_cnt_q <= cnt_d;
    end
    if (cmd_i.avg_take) begin
      avg_q <= (on_cnt_q == '0) ? '0 : div_quot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < N; c++) begin
        last_wall_q[c] <= '0;
        last_idle_q[c] <= '0;
        load_q[c]      <= '0;
      end
      idle_q <= '0;
    end else begin
      if (cmd_i.calc && idx_ok) begin
        last_wall_q[idx] <= smp_q.total_wall_time;
        last_idle_q[idx] <= smp_q.total_idle_time;
        idle_q[idx]      <= smp_q.idle_now;
      end
      if (cmd_i.load_wr && idx_ok) begin
        load_q[idx] <= scaled_load;
      end
    end
  end

  // round decision
  logic [CW:0]   target, run_cnt;
  logic [N-1:0]  mask_d;
  logic [TW-1:0] up_d, down_d;
  logic [1:0]    action_d;
  logic [LW-1:0] up_bar;
  logic          go_up, stop, changed;
  logic [N+MW-1:0] mask_ext;

  always_comb begin
    mask_d   = online_q;
    up_d     = up_q;
    down_d   = down_q;
    action_d = lbhg_pkg::ACT_NONE;
    target   = '0;
    run_cnt  = {1'b0, on_cnt_q};
    stop     = 1'b0;
    changed  = 1'b0;
    up_bar   = (on_cnt_q > CW'(1)) ? one_up_q : lbhg_pkg::SINGLE_UP_LOAD;
    go_up    = (avg_q > up_bar) && (32'(on_cnt_q) < 32'(most_q));
    if (go_up) begin
      up_d   = (up_q < lbhg_pkg::COUNT_MAX) ? up_q + TW'(1) : up_q;
      down_d = '0;
      if (32'(up_d) > 32'(up_hold_q)) begin
        target = ((avg_q > all_up_q) && (on_cnt_q > CW'(1))) ?
                 (CW + 1)'(most_q) : {1'b0, on_cnt_q} + (CW + 1)'(1);
        for (int c = 0; c < N; c++) begin
          if (run_cnt == target) begin
            stop = 1'b1;
          end
          if (!stop && !mask_d[c]) begin
            mask_d[c] = 1'b1;
            run_cnt   = run_cnt + (CW + 1)'(1);
            changed   = 1'b1;
          end
        end
        up_d     = '0;
        down_d   = '0;
        action_d = changed ? lbhg_pkg::ACT_PLUG : lbhg_pkg::ACT_NONE;
      end
    end else begin
      up_d = '0;
      if ((32'(on_cnt_q) > 32'(fewest_q)) && (down_q < lbhg_pkg::COUNT_MAX)) begin
        down_d = down_q + TW'(1);
      end
      if (32'(down_d) > 32'(down_hold_q)) begin
        for (int c = N - 1; c > 0; c--) begin
          if (!changed && mask_d[c] && idle_q[c]) begin
            mask_d[c] = 1'b0;
            changed   = 1'b1;
          end
        end
        up_d     = '0;
        down_d   = '0;
        action_d = changed ? lbhg_pkg::ACT_UNPLUG : lbhg_pkg::ACT_NONE;
      end
    end
  end

  assign mask_ext = {{MW{1'b0}}, mask_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      online_q <= '1;
      up_q     <= '0;
      down_q   <= '0;
    end else if (cfg_we_i && (cfg_idx_i == lbhg_pkg::CFG_ENABLE) && !cfg_data_i[0]) begin
      online_q <= '1;
      up_q     <= '0;
      down_q   <= '0;
    end else if (cmd_i.decide) begin
      online_q <= mask_d;
      up_q     <= up_d;
      down_q   <= down_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.decide) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      out_q.online_cores_mask <= mask_ext[MW-1:0];
      out_q.online_before     <= 3'(on_cnt_q);
      out_q.average_load      <= avg_q;
      out_q.action_taken      <= action_d;
      out_q.up_counter        <= up_d;
      out_q.down_counter      <= down_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign stat_o.enabled    = enable_q;
  assign stat_o.sample_ok  = idx_ok && online_q[idx];
  assign stat_o.degenerate = (wd_q == '0) || (wd_q < id_q);
  assign stat_o.round_end  = smp_q.round_end;
  assign stat_o.div_done   = div_done;
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

endmodule
`default_nettype wire

// File: design/load_based_core_hotplug_governor.sv
// Flow: an accepted sample is ignored, dropped on a degenerate interval, or has its load computed
// by a busy divide, a multiply and a scale divide; a round-end sample while enabled then adds the
// sum, average divide and decision, and its result is registered on the output.
// Throughput: one sample at a time, through up to three passes of the shared 7-step restoring
// divider before the next is taken. A result waiting on the output stalls the next round end.
// Reset: async active low; all cores online, counters and history zero, registers defaulted.
`default_nettype none
module load_based_core_hotplug_governor (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire lbhg_pkg::in_t                    in_data_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output lbhg_pkg::out_t                        out_data_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [lbhg_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [lbhg_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  lbhg_pkg::cmd_t  cmd;
  lbhg_pkg::stat_t stat;

  lbhg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lbhg_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule
`default_nettype wire

// File: design/lbhg_checker.sv
`default_nettype none
module lbhg_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           out_valid_i,
  input wire logic           out_ready_i,
  input wire lbhg_pkg::out_t out_data_i
);

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result request dropped while stalled");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("result request changed while stalled");

  a_core0_online: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i.online_cores_mask[0])
    else $error("core 0 reported offline");

  a_action_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_data_i.action_taken != lbhg_pkg::ACT_NONE) |->
      (out_data_i.up_counter == '0) && (out_data_i.down_counter == '0))
    else $error("counters not cleared after hotplug action");

  a_avg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_data_i.average_load <= lbhg_pkg::FULL_LOAD) &&
      (out_data_i.online_before != 3'd0))
    else $error("average load or online count out of range");

endmodule

bind load_based_core_hotplug_governor lbhg_checker u_lbhg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);
`default_nettype wire
